[rtl/dbsu_pkg.sv]
package dbsu_pkg;

	localparam int STACK_WORDS_DEF = 1024;
	localparam int FRAME_SLOTS_DEF = 256;

	// item field widths
	localparam int OP_W    = 2;
	localparam int WORD_W  = 32;
	localparam int CNTS_W  = 8;
	localparam int SLOT_W  = 8;
	localparam int LEVEL_W = 10;
	localparam int NIB_W   = 4;
	localparam int RUN_W   = 5;   // holds any legal run length, up to MAX_RELEASE
	localparam int HALF_W  = 16;

	localparam int IN_TDATA_W  = 56;  // 50 bits of fields, padded to 7 bytes
	localparam int OUT_TDATA_W = 56;  // 51 bits of fields, padded to 7 bytes

	localparam logic [RUN_W-1:0]  MAX_RELEASE = 5'd31;
	localparam int                MARK_POS    = 31;
	localparam logic [WORD_W-1:0] UNBOUND     = 32'hffff_ffff;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 2'd0,
		OP_BIND    = 2'd1,
		OP_UNBIND  = 2'd2,
		OP_DUNBIND = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_PUSH,
		S_BIND,
		S_ZERO,
		S_BPUSH,
		S_BTOS,
		S_POPRD,
		S_POPWR,
		S_MARK,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_REL_CHK,
		S_REL,
		S_FINAL
	} state_t;

	typedef enum logic [1:0] {
		A_SP,
		A_SP_INC,
		A_SP_DEC,
		A_SCAN_DEC
	} addr_sel_t;

	typedef enum logic [1:0] {
		SP_HOLD,
		SP_INC,
		SP_DEC,
		SP_SCAN
	} sp_op_t;

	typedef enum logic [1:0] {
		SL_HOLD,
		SL_OFF,
		SL_REL,
		SL_DEC
	} slot_op_t;

	typedef enum logic [2:0] {
		CNT_HOLD,
		CNT_N1,
		CNT_N2M1,
		CNT_REL,
		CNT_DEC
	} cnt_op_t;

	typedef enum logic [2:0] {
		K_ZERO,
		K_TOS,
		K_RD,
		K_ONES,
		K_FINAL
	} emit_kind_t;

	typedef struct packed {
		logic       load;
		logic       mem_we;
		logic       mem_re;
		addr_sel_t  asel;
		logic       wdata_marker;  // 0: tos, 1: bind marker
		sp_op_t     sp_op;
		logic       scan_dec;
		logic       marker_from_rd;
		slot_op_t   slot_op;
		cnt_op_t    cnt_op;
		logic       set_fault;
		logic       emit;
		emit_kind_t kind;
	} dbsu_cmd_t;

	typedef struct packed {
		op_t  op;
		logic tos_mark;
		logic push_bad;
		logic bind_bad;
		logic n2_zero;
		logic cnt_zero;
		logic scan_zero;
		logic rd_mark;
		logic rel_bad;
		logic out_free;
	} dbsu_sts_t;

endpackage

[rtl/dbsu_ctrl.sv]
module dbsu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  dbsu_pkg::dbsu_sts_t sts,
	output dbsu_pkg::dbsu_cmd_t cmd
);
	import dbsu_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_PUSH:    state_d = S_PUSH;
					OP_BIND:    state_d = S_BIND;
					OP_UNBIND:  state_d = S_SCAN_RD;
					OP_DUNBIND: state_d = sts.tos_mark ? S_REL_CHK : S_SCAN_RD;
					default:    state_d = S_FINAL;
				endcase
			end
			S_PUSH: begin
				if (sts.push_bad) begin
					cmd.set_fault = 1'b1;
				end else begin
					cmd.mem_we = 1'b1;
					cmd.asel   = A_SP_INC;
					cmd.sp_op  = SP_INC;
				end
				state_d = S_FINAL;
			end
			S_BIND: begin
				if (sts.bind_bad) begin
					cmd.set_fault = 1'b1;
					state_d       = S_FINAL;
				end else begin
					cmd.slot_op = SL_OFF;
					cmd.cnt_op  = CNT_N1;
					state_d     = S_ZERO;
				end
			end
			S_ZERO: begin
				if (sts.cnt_zero) begin
					state_d = sts.n2_zero ? S_BPUSH : S_BTOS;
				end else if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = K_ZERO;
					cmd.slot_op = SL_DEC;
					cmd.cnt_op  = CNT_DEC;
				end
			end
			S_BPUSH: begin
				cmd.mem_we = 1'b1;
				cmd.asel   = A_SP;
				cmd.sp_op  = SP_INC;
				state_d    = S_MARK;
			end
			S_BTOS: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = K_TOS;
					cmd.slot_op = SL_DEC;
					cmd.cnt_op  = CNT_N2M1;
					state_d     = S_POPRD;
				end
			end
			S_POPRD: begin
				if (sts.cnt_zero) begin
					state_d = S_MARK;
				end else begin
					cmd.mem_re = 1'b1;
					cmd.asel   = A_SP_DEC;
					cmd.sp_op  = SP_DEC;
					state_d    = S_POPWR;
				end
			end
			S_POPWR: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = K_RD;
					cmd.slot_op = SL_DEC;
					cmd.cnt_op  = CNT_DEC;
					state_d     = S_POPRD;
				end
			end
			S_MARK: begin
				cmd.mem_we       = 1'b1;
				cmd.asel         = A_SP;
				cmd.wdata_marker = 1'b1;
				state_d          = S_FINAL;
			end
			S_SCAN_RD: begin
				if (sts.scan_zero) begin
					cmd.set_fault = 1'b1;
					state_d       = S_FINAL;
				end else begin
					cmd.mem_re   = 1'b1;
					cmd.asel     = A_SCAN_DEC;
					cmd.scan_dec = 1'b1;
					state_d      = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (sts.rd_mark) begin
					cmd.marker_from_rd = 1'b1;
					state_d            = S_REL_CHK;
				end else begin
					state_d = S_SCAN_RD;
				end
			end
			S_REL_CHK: begin
				if (sts.rel_bad) begin
					cmd.set_fault = 1'b1;
					state_d       = S_FINAL;
				end else begin
					// a marker taken from tos leaves the stack alone
					cmd.sp_op   = (sts.op == OP_DUNBIND && sts.tos_mark) ? SP_HOLD : SP_SCAN;
					cmd.slot_op = SL_REL;
					cmd.cnt_op  = CNT_REL;
					state_d     = S_REL;
				end
			end
			S_REL: begin
				if (sts.cnt_zero) begin
					state_d = S_FINAL;
				end else if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.kind    = K_ONES;
					cmd.slot_op = SL_DEC;
					cmd.cnt_op  = CNT_DEC;
				end
			end
			S_FINAL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.kind = K_FINAL;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

[rtl/dbsu_dp.sv]
module dbsu_dp #(
	parameter int STACK_WORDS = dbsu_pkg::STACK_WORDS_DEF,
	parameter int FRAME_SLOTS = dbsu_pkg::FRAME_SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dbsu_pkg::dbsu_cmd_t          cmd,
	output dbsu_pkg::dbsu_sts_t          sts,
	input  logic [dbsu_pkg::OP_W-1:0]    in_op,
	input  logic [dbsu_pkg::WORD_W-1:0]  in_tos,
	input  logic [dbsu_pkg::CNTS_W-1:0]  in_slot_counts,
	input  logic [dbsu_pkg::SLOT_W-1:0]  in_slot_offset,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic                         out_is_write,
	output logic [dbsu_pkg::SLOT_W-1:0]  out_slot_index,
	output logic [dbsu_pkg::WORD_W-1:0]  out_slot_value,
	output logic [dbsu_pkg::LEVEL_W-1:0] out_stack_level,
	output logic                         out_fault,
	output logic                         out_last
);
	import dbsu_pkg::*;

	localparam int PW  = $clog2(STACK_WORDS);
	localparam int SPW = PW + 1;
	localparam logic [SPW-1:0] SW_L = SPW'(STACK_WORDS);

	// operation registers
	op_t               op_q;
	logic [WORD_W-1:0] tos_q;
	logic [NIB_W-1:0]  n1_q, n2_q;
	logic [SLOT_W-1:0] off_q;
	logic [WORD_W-1:0] marker_q;
	logic              fault_q;

	// working registers
	logic [PW-1:0]     sp_q, scan_q;
	logic [SLOT_W-1:0] slot_q;
	logic [RUN_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rd_q;

	// output register
	logic               ov_q, ow_q, of_q, ol_q;
	logic [SLOT_W-1:0]  oi_q;
	logic [WORD_W-1:0]  oval_q;
	logic [LEVEL_W-1:0] olvl_q;

	logic [WORD_W-1:0] stack_mem [STACK_WORDS];

	// bind checks
	logic [RUN_W-1:0]  nsum;
	logic [WORD_W-1:0] bind_marker;
	logic [SPW-1:0]    sp_ext;
	logic              slot_bad, over_bad, under_bad;

	assign nsum        = RUN_W'(n1_q) + RUN_W'(n2_q);
	assign bind_marker = {~HALF_W'(nsum), 7'd0, off_q, 1'b0};
	assign sp_ext      = SPW'(sp_q);
	assign slot_bad    = (nsum != '0) &&
		((9'(off_q) >= 9'(FRAME_SLOTS)) || (9'(nsum) > 9'(off_q) + 9'd1));
	assign over_bad    = (sp_ext + SPW'(1)) >= SW_L;
	assign under_bad   = (n2_q != '0) && (sp_ext < SPW'(n2_q) - SPW'(1));

	// release checks on the marker
	logic [HALF_W-1:0] rel_num;
	logic [14:0]       rel_top;
	logic              rel_bad;

	assign rel_num = ~marker_q[31:16];
	assign rel_top = marker_q[15:1];
	assign rel_bad = (rel_num != '0) &&
		((rel_num > HALF_W'(MAX_RELEASE)) || (16'(rel_top) >= 16'(FRAME_SLOTS)) ||
		 (17'(rel_num) > 17'(rel_top) + 17'd1));

	logic out_free;
	assign out_free = !ov_q || out_ready;

	always_comb begin
		sts.op        = op_q;
		sts.tos_mark  = tos_q[MARK_POS];
		sts.push_bad  = over_bad;
		sts.bind_bad  = slot_bad || ((n2_q == '0) && over_bad) || under_bad;
		sts.n2_zero   = (n2_q == '0);
		sts.cnt_zero  = (cnt_q == '0);
		sts.scan_zero = (scan_q == '0);
		sts.rd_mark   = rd_q[MARK_POS];
		sts.rel_bad   = rel_bad;
		sts.out_free  = out_free;
	end

	// single memory port
	logic [PW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata;

	always_comb begin
		unique case (cmd.asel)
			A_SP:       mem_addr = sp_q;
			A_SP_INC:   mem_addr = sp_q + PW'(1);
			A_SP_DEC:   mem_addr = sp_q - PW'(1);
			A_SCAN_DEC: mem_addr = scan_q - PW'(1);
			default:    mem_addr = sp_q;
		endcase
		mem_wdata = cmd.wdata_marker ? bind_marker : tos_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			stack_mem[mem_addr] <= mem_wdata;
		end
		if (cmd.mem_re) begin
			rd_q <= stack_mem[mem_addr];
		end
	end

	// operand capture and working payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= op_t'(in_op);
			tos_q    <= in_tos;
			n1_q     <= in_slot_counts[7:4];
			n2_q     <= in_slot_counts[3:0];
			off_q    <= in_slot_offset;
			marker_q <= in_tos;
		end else if (cmd.marker_from_rd) begin
			marker_q <= rd_q;
		end

		case (cmd.slot_op)
			SL_OFF:  slot_q <= off_q;
			SL_REL:  slot_q <= rel_top[SLOT_W-1:0];
			SL_DEC:  slot_q <= slot_q - SLOT_W'(1);
			default: slot_q <= slot_q;
		endcase

		case (cmd.cnt_op)
			CNT_N1:   cnt_q <= RUN_W'(n1_q);
			CNT_N2M1: cnt_q <= RUN_W'(n2_q) - RUN_W'(1);
			CNT_REL:  cnt_q <= rel_num[RUN_W-1:0];
			CNT_DEC:  cnt_q <= cnt_q - RUN_W'(1);
			default:  cnt_q <= cnt_q;
		endcase
	end

	// stack pointer, scan pointer and fault flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			scan_q  <= '0;
			fault_q <= 1'b0;
		end else begin
			case (cmd.sp_op)
				SP_INC:  sp_q <= sp_q + PW'(1);
				SP_DEC:  sp_q <= sp_q - PW'(1);
				SP_SCAN: sp_q <= scan_q;
				default: sp_q <= sp_q;
			endcase
			if (cmd.load) begin
				scan_q <= sp_q;
			end else if (cmd.scan_dec) begin
				scan_q <= scan_q - PW'(1);
			end
			if (cmd.load) begin
				fault_q <= 1'b0;
			end else if (cmd.set_fault) begin
				fault_q <= 1'b1;
			end
		end
	end

	// result register
	logic [31:0] sp_wide;
	assign sp_wide = 32'(sp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ow_q   <= (cmd.kind != K_FINAL);
			ol_q   <= (cmd.kind == K_FINAL);
			oi_q   <= (cmd.kind == K_FINAL) ? '0 : slot_q;
			olvl_q <= (cmd.kind == K_FINAL) ? sp_wide[LEVEL_W-1:0] : '0;
			of_q   <= (cmd.kind == K_FINAL) ? fault_q : 1'b0;
			case (cmd.kind)
				K_TOS:   oval_q <= tos_q;
				K_RD:    oval_q <= rd_q;
				K_ONES:  oval_q <= UNBOUND;
				default: oval_q <= '0;
			endcase
		end
	end

	assign out_valid       = ov_q;
	assign out_is_write    = ow_q;
	assign out_slot_index  = oi_q;
	assign out_slot_value  = oval_q;
	assign out_stack_level = olvl_q;
	assign out_fault       = of_q;
	assign out_last        = ol_q;

endmodule

[rtl/dynamic_bind_stack_unit.sv]
// Dynamic bind stack unit: runs push, bind, unbind and dunbind on an
// evaluation stack held in a single-port memory of STACK_WORDS words and a
// stack pointer that reset sets to zero. Each input item carries one
// operation; the unit answers with one item per frame slot written (tuser
// high), in write order, and then one final item (tuser low, tlast high)
// that carries the stack pointer and the fault flag. Frame slot writes are
// only reported, so the slot store lives downstream. One item is worked at
// a time. An unbind reads stack words down to its marker, and an output
// stall holds the sequencer; the pace is set by the one memory access per
// cycle and the registered read. A faulting operation writes nothing and
// returns only the final item. The stack memory is not cleared at reset:
// reading a word that was never written gives an undefined value. A
// finished result waits in an output register while the next input item
// is taken.
module dynamic_bind_stack_unit #(
	parameter int STACK_WORDS = dbsu_pkg::STACK_WORDS_DEF,
	parameter int FRAME_SLOTS = dbsu_pkg::FRAME_SLOTS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// op[1:0], tos[33:2], slot_counts[41:34], slot_offset[49:42], zero pad
	input  logic [dbsu_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// slot_index[7:0], slot_value[39:8], stack_level[49:40], fault[50], zero pad
	output logic [dbsu_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// is_write[0]
	output logic                                m_tuser,
	output logic                                m_tlast
);
	import dbsu_pkg::*;

	dbsu_cmd_t cmd;
	dbsu_sts_t sts;

	logic [SLOT_W-1:0]  slot_index;
	logic [WORD_W-1:0]  slot_value;
	logic [LEVEL_W-1:0] stack_level;
	logic               fault;

	// sequencer: one state per step of the operation
	dbsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// stack memory, pointers, counters and the result register
	dbsu_dp #(
		.STACK_WORDS (STACK_WORDS),
		.FRAME_SLOTS (FRAME_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_op           (s_tdata[1:0]),
		.in_tos          (s_tdata[33:2]),
		.in_slot_counts  (s_tdata[41:34]),
		.in_slot_offset  (s_tdata[49:42]),
		.out_ready       (m_tready),
		.out_valid       (m_tvalid),
		.out_is_write    (m_tuser),
		.out_slot_index  (slot_index),
		.out_slot_value  (slot_value),
		.out_stack_level (stack_level),
		.out_fault       (fault),
		.out_last        (m_tlast)
	);

	assign m_tdata = {5'd0, fault, stack_level, slot_value, slot_index};

endmodule

[rtl/dbsu_checker.sv]
module dbsu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [dbsu_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             m_tuser,
	input logic                             m_tlast
);
	import dbsu_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// slot write items never close the run and carry no status
	a_write_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> !m_tlast && (m_tdata[50:40] == '0))
		else $error("slot write item carries status");

	// the status item closes the run and carries no slot
	a_final_item: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && (m_tdata[39:0] == '0))
		else $error("final item malformed");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken while busy");

endmodule

bind dynamic_bind_stack_unit dbsu_checker u_dbsu_checker (.*);
